// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/modinv_pkg.sv =====
// ---------------------------------------------------------------------------
// modinv_pkg
// Types and constants shared by the modular inverse block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package modinv_pkg;

   localparam int DATA_W  = 32;
   localparam int LIMIT_W = 32;
   localparam int CMP_W   = (DATA_W + 1 > LIMIT_W) ? DATA_W + 1 : LIMIT_W;
   localparam int CNT_W   = $clog2(DATA_W);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000000);

   typedef struct packed {
      logic [DATA_W-1:0] modulus_k;
      logic [DATA_W-1:0] value_c;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] answer;
      logic              impossible;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic r2_zero;
      logic div_last;
   } status_type;

endpackage

// ===== rtl/modinv_datapath.sv =====
// ---------------------------------------------------------------------------
// modinv_datapath
// Euclid remainders, Bezout magnitudes, bit-serial divider and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modinv_datapath (
   input  logic                             clock,
   input  modinv_pkg::cmd_type              cmd,
   input  modinv_pkg::req_type              req_payload,
   input  logic [modinv_pkg::LIMIT_W-1:0]   limit,
   output modinv_pkg::status_type           status,
   output modinv_pkg::rsp_type              rsp_payload
);
   import modinv_pkg::*;

   logic [DATA_W-1:0] k_ff, k_in;
   logic [DATA_W-1:0] r1_ff, r1_in;
   logic [DATA_W-1:0] r2_ff, r2_in;
   logic [DATA_W-1:0] m_prev_ff, m_prev_in;
   logic [DATA_W-1:0] m_cur_ff, m_cur_in;
   logic              neg_prev_ff, neg_prev_in;
   logic              neg_cur_ff, neg_cur_in;
   logic              c_one_ff, c_one_in;
   logic              k_one_ff, k_one_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DATA_W:0]   shifted;
   logic              q_bit;
   logic [DATA_W:0]   k_plus_one;
   logic [DATA_W-1:0] inv;
   logic              inv_bad;
   logic              k1_bad;

   // one quotient bit per cycle; the product q*m_cur builds up MSB first
   always_comb begin
      shifted = {rem_ff, dvd_ff[DATA_W-1]};
      q_bit   = (shifted >= {1'b0, r2_ff});
   end

   always_comb begin
      k_plus_one = {1'b0, k_ff} + (DATA_W+1)'(1);
      k1_bad     = CMP_W'(k_plus_one) > CMP_W'(limit);
      inv        = (neg_prev_ff && (m_prev_ff != '0)) ? (k_ff - m_prev_ff) : m_prev_ff;
      inv_bad    = (r1_ff != DATA_W'(1)) || (CMP_W'(inv) > CMP_W'(limit));
   end

   always_comb begin
      k_in        = k_ff;
      r1_in       = r1_ff;
      r2_in       = r2_ff;
      m_prev_in   = m_prev_ff;
      m_cur_in    = m_cur_ff;
      neg_prev_in = neg_prev_ff;
      neg_cur_in  = neg_cur_ff;
      c_one_in    = c_one_ff;
      k_one_in    = k_one_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      prod_in     = prod_ff;
      cnt_in      = cnt_ff;
      rsp_in      = rsp_ff;
      if (cmd.load) begin
         k_in        = req_payload.modulus_k;
         r1_in       = req_payload.modulus_k;
         r2_in       = req_payload.value_c;
         m_prev_in   = '0;
         m_cur_in    = DATA_W'(1);
         neg_prev_in = 1'b0;
         neg_cur_in  = 1'b0;
         c_one_in    = (req_payload.value_c == DATA_W'(1));
         k_one_in    = (req_payload.modulus_k == DATA_W'(1));
      end
      if (cmd.div_init) begin
         dvd_in  = r1_ff;
         rem_in  = '0;
         prod_in = '0;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         dvd_in  = {dvd_ff[DATA_W-2:0], 1'b0};
         rem_in  = q_bit ? DATA_W'(shifted - {1'b0, r2_ff}) : shifted[DATA_W-1:0];
         prod_in = {prod_ff[DATA_W-2:0], 1'b0} + (q_bit ? m_cur_ff : '0);
         cnt_in  = cnt_ff + CNT_W'(1);
      end
      if (cmd.update) begin
         r1_in       = r2_ff;
         r2_in       = rem_ff;
         m_prev_in   = m_cur_ff;
         m_cur_in    = m_prev_ff + prod_ff;
         neg_prev_in = neg_cur_ff;
         neg_cur_in  = ~neg_cur_ff;
      end
      if (cmd.capture) begin
         if (c_one_ff) begin
            rsp_in.impossible = k1_bad;
            rsp_in.answer     = k1_bad ? '0 : k_plus_one[DATA_W-1:0];
         end else if (k_one_ff) begin
            rsp_in.impossible = 1'b0;
            rsp_in.answer     = DATA_W'(1);
         end else begin
            rsp_in.impossible = inv_bad;
            rsp_in.answer     = inv_bad ? '0 : inv;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      m_prev_ff   <= m_prev_in;
      m_cur_ff    <= m_cur_in;
      neg_prev_ff <= neg_prev_in;
      neg_cur_ff  <= neg_cur_in;
      c_one_ff    <= c_one_in;
      k_one_ff    <= k_one_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign status.special  = c_one_ff | k_one_ff;
   assign status.r2_zero  = (r2_ff == '0);
   assign status.div_last = (cnt_ff == CNT_W'(DATA_W - 1));
   assign rsp_payload     = rsp_ff;

endmodule

// ===== rtl/modinv_ctrl.sv =====
// ---------------------------------------------------------------------------
// modinv_ctrl
// Sequencer for the Euclid loop: check, divide bit by bit, update, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modinv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  modinv_pkg::status_type status,
   output logic                   busy,
   output modinv_pkg::cmd_type    cmd
);
   import modinv_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.special || status.r2_zero) begin
               state_in = ST_RESULT;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_RESULT: begin
            cmd.capture = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/modular_inverse_with_limit.sv =====
// When c or k is one no Euclid step runs; else n Euclid steps run, one per quotient.
// n is at most about 46 for 32-bit operands.
// Each step runs one restoring division, one quotient bit per cycle, with the
// Bezout product accumulated alongside; one item at a time, start taken when busy is low.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous reset returns the sequencer to idle and the limit to 1000000000.
// ---------------------------------------------------------------------------
// modular_inverse_with_limit
// Modular inverse by extended Euclid with a configurable answer limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_inverse_with_limit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  modinv_pkg::req_type            req_payload,
   output logic                           rsp_valid,
   output modinv_pkg::rsp_type            rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [modinv_pkg::LIMIT_W-1:0] csr_wdata
);
   import modinv_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign csr_ready = 1'b1;

   always_comb begin
      limit_in     = (csr_valid && csr_ready) ? csr_wdata : limit_ff;
      rsp_valid_in = cmd.capture;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   modinv_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   modinv_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .req_payload (req_payload),
      .limit       (limit_ff),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while busy")
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted item not started")
   `ASSERT_IMPLIES(a_rsp_zero, clock, reset, rsp_valid && rsp_payload.impossible, rsp_payload.answer == '0, "impossible result with nonzero answer")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the modular inverse block: a directed table at the
// reset limit, then random phases at several limits, each result checked
// against its table entry or an in-bench extended Euclid model.
// ---------------------------------------------------------------------------

module tb;
   import modinv_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_payload;
   logic                rsp_valid;
   rsp_type             rsp_payload;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_wdata;

   typedef struct {
      logic [DATA_W-1:0] k;
      logic [DATA_W-1:0] c;
      bit                typed;
      rsp_type           rsp;
   } row_type;

   rsp_type             inverse_q[$];
   row_type             rows[$];
   logic [LIMIT_W-1:0]  limit_now;
   int                  err_count;

   modular_inverse_with_limit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(50_000_000);
      $display("FAILURE");
      $finish;
   end

   // inverse of c mod k with the limit check; coefficient kept as magnitude + sign
   function automatic rsp_type inverse_predict(req_type r, logic [LIMIT_W-1:0] lim);
      logic [63:0] k, c, a, b, t, q, m_prev, m_cur, m_next, ans;
      logic        neg_prev, neg_cur, bad;
      rsp_type     o;
      k = 64'(r.modulus_k);
      c = 64'(r.value_c);
      ans = 64'd0;
      bad = 1'b0;
      if (c == 64'd1) begin
         ans = k + 64'd1;
         bad = ans > 64'(lim);
      end else if (k == 64'd1) begin
         ans = 64'd1;
      end else begin
         a = k;
         b = c;
         while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
         end
         if (a != 64'd1) begin
            bad = 1'b1;
         end else begin
            a = k;
            b = c;
            m_prev = 64'd0;
            m_cur = 64'd1;
            neg_prev = 1'b0;
            neg_cur = 1'b0;
            while (b != 64'd0) begin
               q = a / b;
               t = a - b * q;
               m_next = m_prev + q * m_cur;
               a = b;
               b = t;
               m_prev = m_cur;
               m_cur = m_next;
               neg_prev = neg_cur;
               neg_cur = ~neg_cur;
            end
            ans = (neg_prev && m_prev != 64'd0) ? k - m_prev : m_prev;
            bad = ans > 64'(lim);
         end
      end
      if (bad)
         ans = 64'd0;
      o.answer = ans[DATA_W-1:0];
      o.impossible = bad;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   task automatic add_row(logic [DATA_W-1:0] k, logic [DATA_W-1:0] c, bit typed,
                          logic [DATA_W-1:0] ans, logic imp);
      row_type r;
      r.k = k;
      r.c = c;
      r.typed = typed;
      r.rsp.answer = ans;
      r.rsp.impossible = imp;
      rows.push_back(r);
   endtask

   // hold start until the item is taken, then queue its expected result
   task automatic send_item(req_type r, bit typed, rsp_type typed_rsp);
      @(negedge clock);
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      if (typed)
         inverse_q.push_back(typed_rsp);
      else
         inverse_q.push_back(inverse_predict(r, limit_now));
   endtask

   task automatic sender_gap(bit quiet);
      if (!quiet && $urandom_range(0, 99) < 31) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   // drop start before draining, so the last item is not taken a second time
   task automatic write_limit(logic [LIMIT_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (busy || inverse_q.size() != 0) @(posedge clock);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      limit_now = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (inverse_q.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_payload), 64'd0);
         end else begin
            want = inverse_q.pop_front();
            if (rsp_payload.answer !== want.answer)
               report_mismatch("answer", 64'(rsp_payload.answer), 64'(want.answer));
            if (rsp_payload.impossible !== want.impossible)
               report_mismatch("impossible", 64'(rsp_payload.impossible),
                               64'(want.impossible));
         end
      end
   end

   initial begin
      req_type            r;
      rsp_type            none;
      logic [LIMIT_W-1:0] limits[5];
      logic [63:0]        base;
      logic [31:0]        g;
      int                 sel;

      err_count = 0;
      limit_now = LIMIT_RESET;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      none = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, at the reset limit
      add_row(32'hFFFF_FFFF, 32'd1,         1, 32'd0,          1'b1); // k+1 overflows
      add_row(32'd999999999, 32'd1,         1, 32'd1000000000, 1'b0); // exactly at limit
      add_row(32'd1000000000, 32'd1,        1, 32'd0,          1'b1); // one over
      add_row(32'd1,         32'd1,         1, 32'd2,          1'b0);
      add_row(32'd1,         32'hFFFF_FFFF, 1, 32'd1,          1'b0);
      add_row(32'd1,         32'd0,         1, 32'd1,          1'b0); // c zero, k one
      add_row(32'd0,         32'd1,         1, 32'd1,          1'b0); // k zero, c one
      add_row(32'd0,         32'd5,         1, 32'd0,          1'b1); // k zero
      add_row(32'd10,        32'd0,         1, 32'd0,          1'b1); // c zero
      add_row(32'd0,         32'd0,         1, 32'd0,          1'b1);
      add_row(32'd12,        32'd8,         1, 32'd0,          1'b1); // common factor
      add_row(32'd7,         32'd3,         1, 32'd5,          1'b0);
      add_row(32'd7,         32'd10,        1, 32'd5,          1'b0); // c above k
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0,          1'b1);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 32'd0,          1'b1); // inverse k-1 too big
      add_row(32'd2,         32'd3,         0, 32'd0,          1'b0);
      add_row(32'd13,        32'd12,        0, 32'd0,          1'b0);
      add_row(32'hFFFF_FFFB, 32'd2,         0, 32'd0,          1'b0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'd0,          1'b0);
      add_row(32'd100,       32'h5555_5555, 0, 32'd0,          1'b0);
      add_row(32'hAAAA_AAAB, 32'h5555_5555, 0, 32'd0,          1'b0);
      add_row(32'd2971215073, 32'd1836311903, 0, 32'd0,        1'b0); // longest Euclid run
      add_row(32'd1000003,   32'd999999,    0, 32'd0,          1'b0);

      foreach (rows[i]) begin
         r.modulus_k = rows[i].k;
         r.value_c = rows[i].c;
         send_item(r, rows[i].typed, rows[i].rsp);
         sender_gap(1'b0);
      end

      limits[0] = '0;
      limits[1] = '1;
      limits[2] = $urandom;
      limits[3] = LIMIT_W'($urandom_range(1, 1000));
      limits[4] = LIMIT_RESET;

      for (int ph = 0; ph < 5; ph++) begin
         write_limit(limits[ph]);
         for (int n = 0; n < 76; n++) begin
            sel = $urandom_range(0, 99);
            r.modulus_k = $urandom;
            r.value_c = $urandom;
            if (sel < 10) begin
               r.value_c = 1;
               if (sel < 5) begin
                  base = 64'(limit_now) + 64'($urandom_range(0, 2)) - 64'd1;
                  r.modulus_k = base[DATA_W-1:0];
               end
            end else if (sel < 15) begin
               r.modulus_k = 1;
            end else if (sel < 25) begin
               r.modulus_k = $urandom_range(2, 255);
               if (sel < 20)
                  r.value_c = $urandom_range(1, 300);
            end else if (sel < 33) begin
               r.modulus_k = $urandom_range(2, 65535);
            end else if (sel < 40) begin
               g = $urandom_range(2, 5000);
               r.modulus_k = g * $urandom_range(1, 800000);
               r.value_c = g * $urandom_range(1, 800000);
            end
            send_item(r, 1'b0, none);
            sender_gap(ph == 1);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
